// ----- rtl/mqd_pkg.sv -----
// Shared constants, register indexes and lane types for the quadrature decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package mqd_pkg;

    localparam int CHANNELS    = 6;
    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;

    // Widest value used in the limit compare: both sides sign-extended to this.
    localparam int CMP_WIDTH = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 1;

    localparam int IN_FIELD_W  = 2 * CHANNELS;
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = CHANNELS * COUNT_WIDTH + CHANNELS;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = LIMIT_WIDTH;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAX_LIMIT = 1'b0,
        REG_MIN_LIMIT = 1'b1
    } cfg_reg_t;

    localparam logic signed [LIMIT_WIDTH-1:0] MAX_LIMIT_RST = {1'b0, {(LIMIT_WIDTH-1){1'b1}}};
    localparam logic signed [LIMIT_WIDTH-1:0] MIN_LIMIT_RST = {1'b1, {(LIMIT_WIDTH-1){1'b0}}};

    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // Step codes: difference of Gray-cycle positions, mod 4.
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] count;
        logic                          stalled;
    } lane_result_t;

    // Position of a phase in the cycle 00,01,11,10.
    function automatic logic [1:0] gray_pos(input logic [1:0] phase);
        gray_pos = {phase[1], phase[1] ^ phase[0]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/multichannel_quadrature_decoder_top.sv -----
// Top level of the six-channel x4 quadrature decoder.
// Depends on mqd_pkg, mqd_lane and mqd_merge.
`default_nettype none
// Each request on the s_ side is one sample of the A and B pins of all six
// channels; each produces exactly one result on the m_ side with the six
// signed 16-bit counts and the sticky stall mask after that sample. Steps
// along 00,01,11,10 count up, the reverse counts down, repeats and two-bit
// jumps are ignored, and counts saturate at the 16-bit bounds. The first
// sample after reset only loads the phase history. Stall flags set when an
// up step ends at or above max_limit or a down step ends at or below
// min_limit, and stay set until reset. Throughput is one sample per clock unless
// a held result drops s_tready: six lanes update in parallel, and the registered
// result stage lets a new sample in on the same edge the previous result leaves.
// Each result appears in the cycle after its request is taken. The user writes limits
// via cfg_we/cfg_addr/cfg_wdata (0 = max_limit, 1 = min_limit) only while idle; not enforced.
module multichannel_quadrature_decoder_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [mqd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [mqd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // sample requests
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mqd_pkg::IN_TDATA_W-1:0]      s_tdata,  // enc_a[5:0], enc_b[11:6], pad
    // results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mqd_pkg::OUT_TDATA_W-1:0]          m_tdata   // count_ch0..5 (16b each), stall_mask, pad
);
    import mqd_pkg::*;

    logic signed [LIMIT_WIDTH-1:0]      max_limit_reg;
    logic signed [LIMIT_WIDTH-1:0]      min_limit_reg;
    logic                               primed_reg;
    logic                               step;
    logic [CHANNELS-1:0]                enc_a;
    logic [CHANNELS-1:0]                enc_b;
    lane_result_t [CHANNELS-1:0]        lane_next;

    // Take a new sample whenever the result slot is free or being emptied.
    assign s_tready = !m_tvalid || m_tready;
    assign step     = s_tvalid && s_tready;

    assign enc_a = s_tdata[CHANNELS-1:0];
    assign enc_b = s_tdata[2*CHANNELS-1:CHANNELS];

    // Limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_limit_reg <= MAX_LIMIT_RST;
            min_limit_reg <= MIN_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MAX_LIMIT: max_limit_reg <= cfg_wdata;
                REG_MIN_LIMIT: min_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // First sample only primes the phase history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (step) begin
            primed_reg <= 1'b1;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        mqd_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .primed    (primed_reg),
            .enc_a     (enc_a[g]),
            .enc_b     (enc_b[g]),
            .max_limit (max_limit_reg),
            .min_limit (min_limit_reg),
            .lane_next (lane_next[g])
        );
    end

    mqd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step),
        .lane_next (lane_next),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ----- rtl/mqd_lane.sv -----
// One decoder channel: phase history, saturating position count and stall flag.
// Depends on mqd_pkg.
`default_nettype none
module mqd_lane (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step,
    input  wire logic                                 primed,
    input  wire logic                                 enc_a,
    input  wire logic                                 enc_b,
    input  wire logic signed [mqd_pkg::LIMIT_WIDTH-1:0] max_limit,
    input  wire logic signed [mqd_pkg::LIMIT_WIDTH-1:0] min_limit,
    output mqd_pkg::lane_result_t                     lane_next
);
    import mqd_pkg::*;

    logic [1:0]                    phase_reg;
    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic                          stalled_reg;

    logic [1:0]                    cur_phase;
    logic [1:0]                    diff;
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic                          stalled_next;
    logic signed [CMP_WIDTH-1:0]   count_ext;
    logic signed [CMP_WIDTH-1:0]   max_ext;
    logic signed [CMP_WIDTH-1:0]   min_ext;

    always_comb begin
        cur_phase    = {enc_a, enc_b};
        diff         = gray_pos(cur_phase) - gray_pos(phase_reg);
        count_next   = count_reg;
        stalled_next = stalled_reg;
        if (primed) begin
            case (diff)
                STEP_UP: begin
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                end
                STEP_DOWN: begin
                    if (count_reg != COUNT_MIN) begin
                        count_next = count_reg - COUNT_WIDTH'(1);
                    end
                end
                default: ;
            endcase
        end
        count_ext = CMP_WIDTH'(count_next);
        max_ext   = CMP_WIDTH'(max_limit);
        min_ext   = CMP_WIDTH'(min_limit);
        if (primed && diff == STEP_UP && count_ext >= max_ext) begin
            stalled_next = 1'b1;
        end
        if (primed && diff == STEP_DOWN && count_ext <= min_ext) begin
            stalled_next = 1'b1;
        end
        lane_next.count   = count_next;
        lane_next.stalled = stalled_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 2'b00;
            count_reg   <= '0;
            stalled_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= cur_phase;
            count_reg   <= count_next;
            stalled_reg <= stalled_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mqd_merge.sv -----
// Result stage: gathers the lane results into one output word and holds it
// until the downstream side takes it. Depends on mqd_pkg.
`default_nettype none
module mqd_merge (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         load,
    input  wire mqd_pkg::lane_result_t [mqd_pkg::CHANNELS-1:0] lane_next,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    output logic [mqd_pkg::OUT_TDATA_W-1:0]                   m_tdata
);
    import mqd_pkg::*;

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic [OUT_TDATA_W-1:0] data_next;

    always_comb begin
        data_next = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            data_next[i*COUNT_WIDTH +: COUNT_WIDTH] = lane_next[i].count;
            data_next[CHANNELS*COUNT_WIDTH + i]     = lane_next[i].stalled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

// ----- test/mqd_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the six-channel quadrature decoder: tracks limit writes,
// predicts one result per accepted sample and compares it field by field. Uses mqd_pkg.
module mqd_result_checker
    import mqd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     mismatches,
    output int                     outstanding,
    output int                     results_seen
);

    typedef struct packed {
        logic [CHANNELS-1:0]                  stall_mask;
        logic [CHANNELS-1:0][COUNT_WIDTH-1:0] counts;
    } tick_counts_t;

    logic signed [LIMIT_WIDTH-1:0] max_lim;
    logic signed [LIMIT_WIDTH-1:0] min_lim;
    logic [1:0]                    last_phase [CHANNELS];
    logic signed [COUNT_WIDTH-1:0] position [CHANNELS];
    logic [CHANNELS-1:0]           stalled;
    logic                          primed;
    tick_counts_t                  pending_counts [$];

    // index of a phase along 00,01,11,10
    function automatic logic [1:0] phase_rank(input logic [1:0] ph);
        case (ph)
            2'b00:   phase_rank = 2'd0;
            2'b01:   phase_rank = 2'd1;
            2'b11:   phase_rank = 2'd2;
            default: phase_rank = 2'd3;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic decode_tick(input logic [CHANNELS-1:0] a, input logic [CHANNELS-1:0] b,
                               output tick_counts_t res);
        logic [1:0] cur;
        logic [1:0] step;
        int i;
        for (i = 0; i < CHANNELS; i++) begin
            cur = {a[i], b[i]};
            if (primed) begin
                step = phase_rank(cur) - phase_rank(last_phase[i]);
                if (step == STEP_UP) begin
                    if (position[i] != COUNT_MAX)
                        position[i] = position[i] + 16'sd1;
                    if (position[i] >= max_lim)
                        stalled[i] = 1'b1;
                end else if (step == STEP_DOWN) begin
                    if (position[i] != COUNT_MIN)
                        position[i] = position[i] - 16'sd1;
                    if (position[i] <= min_lim)
                        stalled[i] = 1'b1;
                end
            end
            last_phase[i] = cur;
        end
        primed = 1'b1;
        for (i = 0; i < CHANNELS; i++)
            res.counts[i] = position[i];
        res.stall_mask = stalled;
    endtask

    always @(posedge aclk) begin : monitor
        tick_counts_t res;
        tick_counts_t want;
        logic [COUNT_WIDTH-1:0] got;
        logic [CHANNELS-1:0] got_mask;
        int i;
        if (!aresetn) begin
            max_lim = MAX_LIMIT_RST;
            min_lim = MIN_LIMIT_RST;
            for (i = 0; i < CHANNELS; i++) begin
                last_phase[i] = 2'b00;
                position[i]   = '0;
            end
            stalled = '0;
            primed  = 1'b0;
            pending_counts.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_MAX_LIMIT)
                    max_lim = cfg_wdata;
                else if (cfg_addr == REG_MIN_LIMIT)
                    min_lim = cfg_wdata;
            end
            // retire before predicting, so a same-edge request never matches itself
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_counts.size() == 0) begin
                    report_mismatch("result with no request waiting");
                end else begin
                    want = pending_counts.pop_front();
                    for (i = 0; i < CHANNELS; i++) begin
                        got = m_tdata[i*COUNT_WIDTH +: COUNT_WIDTH];
                        if (got !== want.counts[i])
                            report_mismatch($sformatf("count_ch%0d got %0d expected %0d",
                                i, $signed(got), $signed(want.counts[i])));
                    end
                    got_mask = m_tdata[CHANNELS*COUNT_WIDTH +: CHANNELS];
                    if (got_mask !== want.stall_mask)
                        report_mismatch($sformatf("stall_mask got %b expected %b",
                            got_mask, want.stall_mask));
                end
            end
            if (s_tvalid && s_tready) begin
                decode_tick(s_tdata[CHANNELS-1:0], s_tdata[2*CHANNELS-1:CHANNELS], res);
                pending_counts.push_back(res);
            end
        end
        outstanding = pending_counts.size();
    end

endmodule

// ----- test/multichannel_quadrature_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// Top of the quadrature decoder testbench: clock, reset, sample and limit stimulus,
// result backpressure and verdict. Depends on mqd_pkg, the decoder and mqd_result_checker.
module multichannel_quadrature_decoder_top_tb;
    import mqd_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // enc_a, enc_b, zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // count_ch0..count_ch5, stall_mask, zero pad

    int mismatches;
    int outstanding;
    int results_seen;

    bit         idle_on;        // random gaps on both sides when set
    int         hold_asked;     // bumped to ask the sink for one long hold-off
    int         sent;
    int         limit_writes;
    logic [1:0] rank_now [CHANNELS];   // Gray-cycle position last sent per channel

    multichannel_quadrature_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mqd_result_checker tick_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #400_000;
        $display("status: fail");
        $finish;
    end

    // phase for a Gray-cycle position
    function automatic logic [1:0] rank_phase(input logic [1:0] r);
        case (r)
            2'd0:    rank_phase = 2'b00;
            2'd1:    rank_phase = 2'b01;
            2'd2:    rank_phase = 2'b11;
            default: rank_phase = 2'b10;
        endcase
    endfunction

    // One sample request. Entered and left at a falling edge; valid stays up
    // across back-to-back requests so it is never dropped and raised in one step.
    task automatic send_tick(input logic [CHANNELS-1:0] a, input logic [CHANNELS-1:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-2*CHANNELS){1'b0}}, b, a};
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_ranks();
        logic [CHANNELS-1:0] a;
        logic [CHANNELS-1:0] b;
        logic [1:0] ph;
        int i;
        for (i = 0; i < CHANNELS; i++) begin
            ph   = rank_phase(rank_now[i]);
            a[i] = ph[1];
            b[i] = ph[0];
        end
        send_tick(a, b);
    endtask

    // Same phase on every channel.
    task automatic send_phase(input logic [1:0] ph);
        send_tick({CHANNELS{ph[1]}}, {CHANNELS{ph[0]}});
    endtask

    // Stop offering and wait out every pending result, plus the registered result stage.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_limit(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        limit_writes++;
    endtask

    // Random walk per channel: mostly single steps with a bias, some holds,
    // some two-bit jumps, and now and then a fully random sample.
    task automatic walk(input int n, input int up_pct, input int down_pct);
        int k;
        int i;
        int r;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 5) begin
                for (i = 0; i < CHANNELS; i++)
                    rank_now[i] = 2'($urandom);
            end else begin
                for (i = 0; i < CHANNELS; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < up_pct)
                        rank_now[i] = rank_now[i] + 2'd1;
                    else if (r < up_pct + down_pct)
                        rank_now[i] = rank_now[i] - 2'd1;
                    else if (r >= 92)
                        rank_now[i] = rank_now[i] + 2'd2;
                end
            end
            send_ranks();
        end
    endtask

    // Monotone run on all channels.
    task automatic sweep(input int n, input bit up);
        int k;
        int i;
        for (k = 0; k < n; k++) begin
            for (i = 0; i < CHANNELS; i++)
                rank_now[i] = up ? rank_now[i] + 2'd1 : rank_now[i] - 2'd1;
            send_ranks();
        end
    endtask

    // Result sink: random stall per result, or one long hold-off on request,
    // counted here while the source keeps pushing.
    initial begin : result_sink
        int stall;
        int served;
        m_tready = 1'b0;
        served   = 0;
        @(posedge aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (hold_asked != served) begin
                served = hold_asked;
                stall  = 300;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [1:0] dir_seq [16];
        logic [CFG_DATA_W-1:0] rnd;
        int guard;
        int k;
        // walk up a full cycle, repeat, walk down, then two-bit jumps mixed in
        dir_seq = '{2'b00, 2'b01, 2'b11, 2'b10, 2'b00, 2'b00, 2'b10, 2'b11,
                    2'b01, 2'b00, 2'b11, 2'b00, 2'b01, 2'b10, 2'b01, 2'b11};
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_MAX_LIMIT;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        idle_on      = 1'b1;
        hold_asked   = 0;
        sent         = 0;
        limit_writes = 0;
        for (k = 0; k < CHANNELS; k++)
            rank_now[k] = 2'd0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: first sample only loads, then every transition kind on all lanes.
        for (k = 0; k < 16; k++)
            send_phase(dir_seq[k]);
        send_tick(6'b101010, 6'b011001);
        send_tick(6'h3F, 6'h00);
        send_tick(6'h00, 6'h3F);
        send_tick(6'h3F, 6'h3F);
        send_tick(6'h00, 6'h00);
        // lanes now all at phase 00, so the walk state below matches
        drain();

        // Random part, limits stepped through between phases.
        walk(250, 40, 40);

        write_limit(REG_MAX_LIMIT, 16'sd40);
        write_limit(REG_MIN_LIMIT, -16'sd40);
        hold_asked++;   // long sink hold-off: decoder fills and stalls the source
        walk(250, 65, 20);

        write_limit(REG_MAX_LIMIT, 16'sd10);
        write_limit(REG_MIN_LIMIT, MIN_LIMIT_RST);
        walk(250, 20, 65);

        write_limit(REG_MAX_LIMIT, MAX_LIMIT_RST);
        write_limit(REG_MIN_LIMIT, -16'sd10);
        idle_on = 1'b0;   // a stretch with no gaps on either side
        walk(250, 40, 40);
        idle_on = 1'b1;

        write_limit(REG_MAX_LIMIT, 16'sd0);
        write_limit(REG_MIN_LIMIT, 16'sd0);
        walk(250, 45, 45);

        write_limit(REG_MAX_LIMIT, MIN_LIMIT_RST);
        write_limit(REG_MIN_LIMIT, MAX_LIMIT_RST);
        walk(250, 40, 40);

        rnd = CFG_DATA_W'($urandom);
        write_limit(REG_MAX_LIMIT, rnd);
        rnd = CFG_DATA_W'($urandom);
        write_limit(REG_MIN_LIMIT, rnd);
        walk(250, 50, 30);

        write_limit(REG_MAX_LIMIT, MAX_LIMIT_RST);
        write_limit(REG_MIN_LIMIT, MIN_LIMIT_RST);
        walk(250, 40, 40);
        drain();

        // Monotone runs back to back: every lane counts up, then down past its start.
        idle_on = 1'b0;
        sweep(60, 1'b1);
        sweep(120, 1'b0);
        idle_on = 1'b1;
        walk(40, 40, 40);

        s_tvalid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (10) @(negedge aclk);

        if (outstanding != 0)
            $display("%0d results never arrived", outstanding);
        $display("covered %0d samples: directed steps, biased walks with jumps and noise,",
            sent);
        $display("  monotone up and down runs, %0d limit writes, %0d results checked",
            limit_writes, results_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
